// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checks in the converter RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: hw/rtl/y2r_pkg.sv
`timescale 1ns / 1ps
package y2r_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_WIDTH  = 2;
  localparam int MIN_HEIGHT = 1;

  // Field and counter widths.
  localparam int PIX_W      = 8;
  localparam int CHROMA_W   = 2 * PIX_W;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int COUNT_W    = $clog2(MAX_WIDTH);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_IDX_W = $clog2(LINE_DEPTH);

  // Q16 arithmetic widths.
  localparam int FRAC_BITS = 16;
  localparam int DIFF_W    = PIX_W + 1;
  localparam int PROD_W    = 26;
  localparam int ACC_W     = 28;

  // Full-range BT.601 coefficients in Q16.
  localparam logic signed [PROD_W-1:0] COEF_RV = PROD_W'(91881);
  localparam logic signed [PROD_W-1:0] COEF_GU = PROD_W'(22554);
  localparam logic signed [PROD_W-1:0] COEF_GV = PROD_W'(46802);
  localparam logic signed [PROD_W-1:0] COEF_BU = PROD_W'(116130);

  localparam logic signed [DIFF_W-1:0] CHROMA_BIAS = DIFF_W'(128);
  localparam logic [PIX_W-1:0]         PIX_MAX     = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Removes the chroma bias and widens to a signed product operand.
  function automatic logic signed [PROD_W-1:0] chroma_diff(input logic [PIX_W-1:0] c);
    logic signed [DIFF_W-1:0] d;
    d = $signed({1'b0, c}) - CHROMA_BIAS;
    return PROD_W'(d);
  endfunction

  // Floors a Q16 sum to an integer and clamps it to the pixel range.
  function automatic logic [PIX_W-1:0] clamp_q16(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] q;
    q = acc >>> FRAC_BITS;
    if (q < 0) begin
      return '0;
    end else if (q > $signed(ACC_W'(PIX_MAX))) begin
      return PIX_MAX;
    end else begin
      return q[PIX_W-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/y2r_if.sv
`timescale 1ns / 1ps
// Pixel item entering the converter: luma with the chroma pair.
interface y2r_pixel_if import y2r_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma;
  logic [PIX_W-1:0] chroma_blue;
  logic [PIX_W-1:0] chroma_red;

  modport source (output valid, luma, chroma_blue, chroma_red, input ready);
  modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface

// RGBA item leaving the converter, with row and frame markers.
interface y2r_rgba_if import y2r_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] alpha;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, red, green, blue, alpha, row_end, frame_end, input ready);
  modport sink   (input valid, red, green, blue, alpha, row_end, frame_end, output ready);
endinterface

// File: hw/rtl/yuv420_to_rgba_converter.sv
`timescale 1ns / 1ps
// 4:2:0 to RGBA converter, full-range BT.601.
// Pixels enter on the pixel channel in raster order, one item per pixel, with
// valid/ready handshakes. Chroma is taken only at even rows and even columns;
// the other inputs ignore it. Results leave on the rgba channel, one item per
// pixel, with row_end and frame_end marking the last pixel of a row and frame.
// Frame size is set through the write port (index 0 width, 1 height); write it
// only while no items are in flight.
// A result is valid once its pixel has passed stages 1, 2 and 3; it leaves from
// the stage 3 output register. Throughput is one item per cycle while the
// receiver takes results; each pixel makes at most one line-store access: even
// columns of even rows write the chroma pair, odd rows read it back for stage 2.
// Reset empties the pipeline, zeroes the row and column counters and loads a
// 640 x 480 frame. The line store is not cleared; every odd row reads entries
// that the even row before it wrote.
// When the receiver stalls, the three pipeline stages keep filling; pixel.ready
// drops only once all of them hold an item.
`include "assert_macros.svh"
module yuv420_to_rgba_converter import y2r_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  y2r_pixel_if.sink            pixel,
  y2r_rgba_if.source           rgba
);

  logic [CFG_W-1:0]      frame_width;
  logic [CFG_W-1:0]      frame_height;
  logic [COUNT_W-1:0]    column_count;
  logic [COUNT_W-1:0]    row_count;
  logic [CHROMA_W-1:0]   chroma_hold;
  logic [CFG_W-1:0]      width_even;
  logic [CFG_W-1:0]      width_eff;
  logic [CFG_W-1:0]      height_eff;
  logic                  row_end_now;
  logic                  frame_end_now;
  logic                  accept;
  logic [CHROMA_W-1:0]   chroma_in;
  logic                  ram_we;
  logic                  ram_re;
  logic [LINE_IDX_W-1:0] line_idx;
  logic [CHROMA_W-1:0]   ram_rdata;

  logic                  en1, en2, en3;
  logic                  v1, v2, v3;
  logic [PIX_W-1:0]      luma1, luma2;
  logic [CHROMA_W-1:0]   chroma1;
  logic                  use_ram1;
  logic                  row_end1, row_end2, row_end3;
  logic                  frame_end1, frame_end2, frame_end3;
  logic [CHROMA_W-1:0]   chroma_sel;
  logic signed [PROD_W-1:0] du, dv;
  logic signed [PROD_W-1:0] prod_rv, prod_gu, prod_gv, prod_bu;
  logic signed [ACC_W-1:0]  y_q16, acc_r, acc_g, acc_b;
  logic [PIX_W-1:0]      red3, green3, blue3;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(640);
      frame_height <= CFG_W'(480);
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame size: even width clamped to its range, height likewise.
  always_comb begin
    width_even = {frame_width[CFG_W-1:1], 1'b0};
    if (width_even < CFG_W'(MIN_WIDTH)) begin
      width_eff = CFG_W'(MIN_WIDTH);
    end else if (width_even > CFG_W'(MAX_WIDTH)) begin
      width_eff = CFG_W'(MAX_WIDTH);
    end else begin
      width_eff = width_even;
    end
    if (frame_height < CFG_W'(MIN_HEIGHT)) begin
      height_eff = CFG_W'(MIN_HEIGHT);
    end else if (frame_height > CFG_W'(MAX_HEIGHT)) begin
      height_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  assign row_end_now   = (CFG_W'(column_count) + CFG_W'(1)) >= width_eff;
  assign frame_end_now = row_end_now && ((CFG_W'(row_count) + CFG_W'(1)) >= height_eff);

  // Stage enables: a stage moves when it is empty or the next one moves.
  assign en3         = !v3 || rgba.ready;
  assign en2         = !v2 || en3;
  assign en1         = !v1 || en2;
  assign pixel.ready = en1;
  assign accept      = pixel.valid && en1;

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_end_now) begin
        column_count <= '0;
        row_count    <= frame_end_now ? '0 : row_count + COUNT_W'(1);
      end else begin
        column_count <= column_count + COUNT_W'(1);
      end
    end
  end

  // Chroma pair capture: even columns of even rows write the line store and the
  // hold register, odd rows read the line store back.
  assign chroma_in = {pixel.chroma_red, pixel.chroma_blue};
  assign line_idx  = column_count[COUNT_W-1:1];
  assign ram_we    = accept && !row_count[0] && !column_count[0];
  assign ram_re    = accept && row_count[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      chroma_hold <= '0;
    end else if (ram_we) begin
      chroma_hold <= chroma_in;
    end
  end

  y2r_ram #(
    .WIDTH (CHROMA_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line_idx),
    .wdata (chroma_in),
    .re    (ram_re),
    .raddr (line_idx),
    .rdata (ram_rdata)
  );

  // Stage 1: pixel waits for the line store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      luma1      <= pixel.luma;
      chroma1    <= column_count[0] ? chroma_hold : chroma_in;
      use_ram1   <= row_count[0];
      row_end1   <= row_end_now;
      frame_end1 <= frame_end_now;
    end
  end

  // Stage 2: chroma products.
  assign chroma_sel = use_ram1 ? ram_rdata : chroma1;
  assign du         = chroma_diff(chroma_sel[PIX_W-1:0]);
  assign dv         = chroma_diff(chroma_sel[CHROMA_W-1:PIX_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      luma2      <= luma1;
      prod_rv    <= dv * COEF_RV;
      prod_gu    <= du * COEF_GU;
      prod_gv    <= dv * COEF_GV;
      prod_bu    <= du * COEF_BU;
      row_end2   <= row_end1;
      frame_end2 <= frame_end1;
    end
  end

  // Stage 3: sums, floor and clamp into the output register.
  assign y_q16 = $signed(ACC_W'({luma2, FRAC_BITS'(0)}));
  assign acc_r = y_q16 + ACC_W'(prod_rv);
  assign acc_g = y_q16 - ACC_W'(prod_gu) - ACC_W'(prod_gv);
  assign acc_b = y_q16 + ACC_W'(prod_bu);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      red3       <= clamp_q16(acc_r);
      green3     <= clamp_q16(acc_g);
      blue3      <= clamp_q16(acc_b);
      row_end3   <= row_end2;
      frame_end3 <= frame_end2;
    end
  end

  assign rgba.valid     = v3;
  assign rgba.red       = red3;
  assign rgba.green     = green3;
  assign rgba.blue      = blue3;
  assign rgba.alpha     = PIX_MAX;
  assign rgba.row_end   = row_end3;
  assign rgba.frame_end = frame_end3;

  // Checks.
  `ASSERT_IMPLIES(a_line_port_excl, clk, rst, ram_we, !ram_re, "line read and write overlap")
  `ASSERT_NEXT(a_col_wrap, clk, rst, accept && row_end_now, column_count == '0, "no col wrap")
  `ASSERT_IMPLIES(a_full_stall, clk, rst, v1 && v2 && v3 && !rgba.ready, !pixel.ready, "full")
  `ASSERT_IMPLIES(a_frame_marks, clk, rst, v3 && frame_end3, row_end3, "frame end, no row end")

endmodule

// File: hw/rtl/y2r_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data.
module y2r_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
